[rtl/fws_pkg.sv]
// shared types, constants and coefficient tables for the fourier waveform synth
`timescale 1ns / 1ps
package fws_pkg;

  // phase and table geometry
  localparam int PHASE_STEPS        = 1024;
  localparam int PHASE_BITS         = $clog2(PHASE_STEPS);
  localparam int MAX_HARMONIC_LIMIT = 15;
  localparam int N_CELLS            = MAX_HARMONIC_LIMIT + 1;
  localparam int CELL_W             = $clog2(N_CELLS);

  // register port
  localparam int AMP_W     = 11;
  localparam int DAC_W     = 12;
  localparam int LIM_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_OFFSET      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HARMONIC_LIMIT = 2'd2;
  localparam logic [AMP_W-1:0] AMP_RESET = 11'd512;
  localparam logic [DAC_W-1:0] DC_RESET  = 12'd612;
  localparam logic [LIM_W-1:0] LIM_RESET = 4'd6;
  localparam logic [DAC_W-1:0] CODE_MAX  = '1;

  // fixed point
  localparam int QF             = 20;
  localparam int SINE_FRAC_BITS = 15;
  localparam int X_W            = QF + 1;
  localparam int SINE_W         = SINE_FRAC_BITS + 2;
  localparam int WEIGHT_W       = 21;
  localparam int PROD_W         = SINE_W + WEIGHT_W + 1;
  localparam int TERM_W         = PROD_W - SINE_FRAC_BITS;
  localparam int ACC_W          = 27;
  localparam int FPROD_W        = ACC_W + AMP_W + 1;
  localparam int SUM_W          = FPROD_W - QF + 1;

  localparam logic [X_W-1:0] POLY_A = 21'd1647100;
  localparam logic [X_W-1:0] POLY_B = 21'd672759;
  localparam logic [X_W-1:0] POLY_C = 21'd74235;

  typedef enum logic [1:0] {
    MODE_SINE,
    MODE_SQUARE,
    MODE_TRIANGLE,
    MODE_SAW
  } wave_mode_t;

  // per-harmonic weights, Q.20, rounded to nearest
  localparam logic [WEIGHT_W-1:0] SQUARE_WT [N_CELLS] = '{
    21'd1335088, 21'd445029, 21'd267018, 21'd190727,
    21'd148343,  21'd121372, 21'd102699, 21'd89006,
    21'd78535,   21'd70268,  21'd63576,  21'd58047,
    21'd53404,   21'd49448,  21'd46038,  21'd43067
  };
  localparam logic [WEIGHT_W-1:0] TRIANGLE_WT [N_CELLS] = '{
    21'd424972, 21'd47219, 21'd16999, 21'd8673,
    21'd5247,   21'd3512,  21'd2515,  21'd1889,
    21'd1470,   21'd1177,  21'd964,   21'd803,
    21'd680,    21'd583,   21'd505,   21'd442
  };
  localparam logic [WEIGHT_W-1:0] SAW_WT [N_CELLS] = '{
    21'd333772, 21'd166886, 21'd111257, 21'd83443,
    21'd66754,  21'd55629,  21'd47682,  21'd41722,
    21'd37086,  21'd33377,  21'd30343,  21'd27814,
    21'd25675,  21'd23841,  21'd22251,  21'd20861
  };

  // settings shared by every cell for the item in flight
  typedef struct packed {
    wave_mode_t             mode;
    logic [LIM_W-1:0]       lim;
    logic [PHASE_BITS-1:0]  step;
  } cell_bcast_t;

  // token handed from cell to cell
  typedef struct packed {
    logic                   valid;
    logic [PHASE_BITS-1:0]  idx;
  } cell_tok_t;

  // term request from the active cell to the sine/weight pipeline
  typedef struct packed {
    logic                   active;
    logic [PHASE_BITS-1:0]  idx;
    logic [WEIGHT_W-1:0]    weight;
    logic                   sub;
    logic                   last;
  } term_req_t;

  typedef struct packed {
    logic                      valid;
    logic                      sub;
    logic                      last;
    logic signed [SINE_W-1:0]  sine;
    logic signed [PROD_W-1:0]  prod;
  } term_res_t;

  function automatic logic [WEIGHT_W-1:0] fws_weight(wave_mode_t m,
                                                     logic [CELL_W-1:0] n);
    logic [WEIGHT_W-1:0] w;
    unique case (m)
      MODE_SQUARE:   w = SQUARE_WT[n];
      MODE_TRIANGLE: w = TRIANGLE_WT[n];
      MODE_SAW:      w = SAW_WT[n];
      default:       w = '0;
    endcase
    return w;
  endfunction

endpackage

[rtl/fws_cell.sv]
// one harmonic cell: holds a term index and hands the advanced index on
`timescale 1ns / 1ps
module fws_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [fws_pkg::CELL_W-1:0] cell_num,
  input  fws_pkg::cell_bcast_t bcast,
  input  fws_pkg::cell_tok_t   tok_in,
  output fws_pkg::cell_tok_t   tok_out,
  output fws_pkg::term_req_t   tap
);
  import fws_pkg::*;

  logic                  valid;
  logic [PHASE_BITS-1:0] idx;
  logic                  more;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= tok_in.valid;
    end
    idx <= tok_in.idx;
  end

  // does the series continue past this cell
  always_comb begin
    unique case (bcast.mode) inside
      MODE_SQUARE, MODE_TRIANGLE: begin
        more = (CELL_W+1)'(cell_num) < (CELL_W+1)'(bcast.lim);
      end
      MODE_SAW: begin
        more = ((CELL_W+1)'(cell_num) + (CELL_W+1)'(1)) < (CELL_W+1)'(bcast.lim);
      end
      default: begin
        more = 1'b0;
      end
    endcase
  end

  assign tok_out.valid = valid && more;
  assign tok_out.idx   = idx + bcast.step;

  assign tap.active = valid;
  assign tap.idx    = idx;
  assign tap.weight = fws_weight(bcast.mode, cell_num);
  assign tap.sub    = (bcast.mode == MODE_SAW) ||
                      ((bcast.mode == MODE_TRIANGLE) && cell_num[0]);
  assign tap.last   = !more;

endmodule

[rtl/fws_sine_term.sv]
// pipelined quarter-wave polynomial sine and harmonic weighting
`timescale 1ns / 1ps
module fws_sine_term (
  input  logic               clk,
  input  logic               rst,
  input  fws_pkg::term_req_t req,
  output fws_pkg::term_res_t res
);
  import fws_pkg::*;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                sub;
    logic                last;
    logic                neg;
  } meta_t;

  localparam logic [X_W-1:0] ONE_Q = X_W'(1) << QF;

  logic [4:0]  v;
  meta_t       m0, m1, m2, m3, m4;
  logic [X_W-1:0] x0, x1, x2_1, x2, x2_2, x3;
  logic [X_W-1:0] inner1, inner2;
  logic signed [SINE_W-1:0] sine5;

  // quadrant fold of the phase index
  logic [PHASE_BITS-3:0] low_bits;
  logic [X_W-1:0]        x_lo;
  logic [X_W-1:0]        x_fold;

  logic [2*X_W-1:0] sq1, p2, p3, p4;
  logic [X_W:0]     s_rnd;
  logic [SINE_W-1:0] mag;
  logic signed [SINE_W-1:0] sine4;
  logic signed [PROD_W-1:0] prod5;

  assign low_bits = req.idx[PHASE_BITS-3:0];
  assign x_lo     = X_W'(low_bits) << (QF - PHASE_BITS + 2);
  assign x_fold   = req.idx[PHASE_BITS-2] ? (ONE_Q - x_lo) : x_lo;

  assign sq1 = x0 * x0;
  assign p2  = x2_1 * POLY_C;
  assign p3  = x2_2 * inner1;
  assign p4  = x3 * inner2;
  assign s_rnd = (X_W+1)'(p4[QF +: X_W]) + (X_W+1)'(1 << (QF - SINE_FRAC_BITS - 1));
  assign mag   = s_rnd[QF - SINE_FRAC_BITS +: SINE_W];
  assign sine4 = m3.neg ? -$signed(mag) : $signed(mag);
  assign prod5 = sine5 * $signed({1'b0, m4.weight});

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      res.valid <= 1'b0;
    end else begin
      v         <= {v[3:0], req.active};
      res.valid <= v[4];
    end
    // stage 0: folded argument
    x0  <= x_fold;
    m0  <= '{weight: req.weight, sub: req.sub, last: req.last,
             neg: req.idx[PHASE_BITS-1]};
    // stage 1: x squared
    x1   <= x0;
    x2_1 <= sq1[QF +: X_W];
    m1   <= m0;
    // stage 2: innermost bracket
    x2     <= x1;
    x2_2   <= x2_1;
    inner1 <= POLY_B - p2[QF +: X_W];
    m2     <= m1;
    // stage 3: outer bracket
    x3     <= x2;
    inner2 <= POLY_A - p3[QF +: X_W];
    m3     <= m2;
    // stage 4: signed sine in Q2.15
    sine5 <= sine4;
    m4    <= m3;
    // stage 5: weighted term
    res.sine <= sine5;
    res.prod <= prod5;
    res.sub  <= m4.sub;
    res.last <= m4.last;
  end

endmodule

[rtl/fourier_waveform_synth_unit.sv]
// top level: registers, harmonic cell row, term pipeline, accumulate and scale
`timescale 1ns / 1ps
// One item (phase, mode) is taken when start is high and busy is low; busy stays high
// until the result appears as a one-cycle done strobe with dac_code and clipped, which
// the receiver must take in that cycle. The number of series terms for an item is 1 for
// sine, limit + 1 for square and triangle, and limit for sawtooth. A sawtooth with a
// zero limit has no terms and goes straight to scaling. The row of harmonic cells
// issues one term per cycle into a six-stage sine and weight pipeline, followed by a
// multiply state and a rounding state. The user must write the registers through
// cfg_valid/cfg_ready only while the block is idle; the block does not enforce this.
module fourier_waveform_synth_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [fws_pkg::PHASE_BITS-1:0]    phase,
  input  logic [1:0]                        mode,
  output logic                              done,
  output logic [fws_pkg::DAC_W-1:0]         dac_code,
  output logic                              clipped,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fws_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fws_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SCALE,
    ST_EMIT
  } state_t;

  localparam logic signed [ACC_W-1:0]   HALF_Q  = ACC_W'(1) << (QF - 1);
  localparam logic signed [PROD_W-1:0]  TERM_RND = PROD_W'(1) << (SINE_FRAC_BITS - 1);
  localparam logic signed [FPROD_W-1:0] OUT_RND  = FPROD_W'(1) << (QF - 1);

  logic [AMP_W-1:0] amplitude;
  logic [DAC_W-1:0] dc_offset;
  logic [LIM_W-1:0] harmonic_limit;

  state_t state;
  cell_bcast_t bcast;
  logic signed [ACC_W-1:0]   acc;
  logic signed [FPROD_W-1:0] fprod;

  logic accept;
  wave_mode_t in_mode;
  logic [LIM_W-1:0] lim_eff;
  logic no_terms;

  cell_tok_t link [N_CELLS];
  cell_tok_t tail_tok;
  term_req_t tap [N_CELLS];
  term_req_t req;
  logic [N_CELLS-1:0] act_vec;
  term_res_t res;

  logic signed [PROD_W-1:0] term_rnd;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  term_ext;
  logic signed [ACC_W-1:0]  sine_ext;

  logic signed [FPROD_W-1:0] fprod_rnd;
  logic signed [SUM_W-2:0]   scaled;
  logic signed [SUM_W-1:0]   code_s;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude      <= AMP_RESET;
      dc_offset      <= DC_RESET;
      harmonic_limit <= LIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_AMPLITUDE:      amplitude      <= cfg_data[AMP_W-1:0];
        CFG_DC_OFFSET:      dc_offset      <= cfg_data[DAC_W-1:0];
        CFG_HARMONIC_LIMIT: harmonic_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept   = start && !busy;
  assign in_mode  = wave_mode_t'(mode);
  assign lim_eff  = (harmonic_limit > LIM_W'(MAX_HARMONIC_LIMIT)) ?
                    LIM_W'(MAX_HARMONIC_LIMIT) : harmonic_limit;
  assign no_terms = (in_mode == MODE_SAW) && (lim_eff == '0);

  // first cell is loaded with the fundamental index
  assign link[0].valid = accept && !no_terms;
  assign link[0].idx   = phase;

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    if (i < N_CELLS - 1) begin : g_mid
      fws_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_num (CELL_W'(i)),
        .bcast    (bcast),
        .tok_in   (link[i]),
        .tok_out  (link[i+1]),
        .tap      (tap[i])
      );
    end else begin : g_end
      fws_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_num (CELL_W'(i)),
        .bcast    (bcast),
        .tok_in   (link[i]),
        .tok_out  (tail_tok),
        .tap      (tap[i])
      );
    end
  end

  // at most one cell holds the token, so its request is the or of all taps
  always_comb begin
    req = '0;
    for (int i = 0; i < N_CELLS; i++) begin
      act_vec[i] = tap[i].active;
      if (tap[i].active) begin
        req = term_req_t'(req | tap[i]);
      end
    end
  end

  fws_sine_term u_sine_term (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  assign term_rnd = res.prod + TERM_RND;
  assign term     = term_rnd[PROD_W-1:SINE_FRAC_BITS];
  assign term_ext = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
  assign sine_ext = {{(ACC_W-SINE_W-(QF-SINE_FRAC_BITS)){res.sine[SINE_W-1]}},
                     res.sine, {(QF-SINE_FRAC_BITS){1'b0}}};

  assign fprod_rnd = fprod + OUT_RND;
  assign scaled    = fprod_rnd[FPROD_W-1:QF];
  assign code_s    = {scaled[SUM_W-2], scaled} +
                     $signed({{(SUM_W-DAC_W){1'b0}}, dc_offset});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            busy       <= 1'b1;
            acc        <= HALF_Q;
            bcast.mode <= in_mode;
            bcast.lim  <= lim_eff;
            bcast.step <= (in_mode == MODE_SQUARE || in_mode == MODE_TRIANGLE) ?
                          {phase[PHASE_BITS-2:0], 1'b0} : phase;
            state      <= no_terms ? ST_SCALE : ST_RUN;
          end
        end
        ST_RUN: begin
          if (res.valid) begin
            if (bcast.mode == MODE_SINE) begin
              acc <= sine_ext;
            end else if (res.sub) begin
              acc <= acc - term_ext;
            end else begin
              acc <= acc + term_ext;
            end
            if (res.last) begin
              state <= ST_SCALE;
            end
          end
        end
        ST_SCALE: begin
          fprod <= $signed({1'b0, amplitude}) * acc;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= ST_IDLE;
          if (code_s[SUM_W-1]) begin
            dac_code <= '0;
            clipped  <= 1'b1;
          end else if (|code_s[SUM_W-2:DAC_W]) begin
            dac_code <= CODE_MAX;
            clipped  <= 1'b1;
          end else begin
            dac_code <= code_s[DAC_W-1:0];
            clipped  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_one_active_cell: assert property (@(posedge clk) disable iff (rst)
    $onehot0(act_vec))
    else $error("more than one harmonic cell active");

  a_tail_never_valid: assert property (@(posedge clk) disable iff (rst)
    !tail_tok.valid)
    else $error("token ran off the end of the cell row");

  a_term_only_in_run: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == ST_RUN))
    else $error("term arrived outside the run phase");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe without a request in flight");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

endmodule
